/* rtl/core/hid_usage_path_stack_matcher_core_assert.svh */
// assertion macros shared by the matcher checker
`ifndef HID_USAGE_PATH_STACK_MATCHER_CORE_ASSERT_SVH
`define HID_USAGE_PATH_STACK_MATCHER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HUPSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hupsm check failed");

// next-cycle implication, disabled during reset
`define HUPSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hupsm check failed");

`endif

/* rtl/core/hupsm_pkg.sv */
// types and codes of the hid usage path stack matcher
package hupsm_pkg;

    localparam int DEPTH_W = 5;

    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP       = 3'd1;
    localparam logic [2:0] CMD_SET_LAST  = 3'd2;
    localparam logic [2:0] CMD_ZERO_LAST = 3'd3;
    localparam logic [2:0] CMD_SET_RID   = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;
    localparam logic [2:0] CMD_COMPARE   = 3'd6;

    localparam logic [2:0] MODE_STRICT   = 3'd0;
    localparam logic [2:0] MODE_PREFIX   = 3'd1;
    localparam logic [2:0] MODE_SUFFIX   = 3'd2;
    localparam logic [2:0] MODE_ANYWHERE = 3'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BADMODE = 2'd2;

    localparam logic PATH_REPORT = 1'b0;
    localparam logic PATH_QUERY  = 1'b1;

    localparam logic TAG_GLOBAL = 1'b0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        path_sel;
        logic [15:0] push_page;
        logic [15:0] usage;
        logic        tag_class;
        logic [15:0] tag_value;
        logic [7:0]  rid_value;
        logic [2:0]  mode;
        logic        page_only;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               matched;
        logic [DEPTH_W-1:0] depth;
    } out_t;

endpackage

/* rtl/core/hupsm_ram.sv */
// generic ram, one write port, two registered read ports
module hupsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/core/hid_usage_path_stack_matcher_core.sv */
// hid usage path stack matcher, top level
//
// keeps a report path and a query path of usage entries (page, usage) in two
// small rams and matches the query against the report path on request. an
// item is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high, the cycle after the item is
// finished, and cannot be held off. edits (push, pop, set last, zero last,
// set report id, clear, unused code) and compares decided by report ids,
// depths or mode alone finish at the accepting edge: result in the next cycle,
// next item may follow right away. a compare that has to look at entries
// walks n entry pairs, n being the query depth (report depth in anywhere
// mode), one pair per cycle through the two read ports of the rams; busy
// stays high until the last pair read has been checked, and the next item
// enters only after busy falls. the walk stops early on the first mismatch
// (or first hit in anywhere mode). entry rams are not cleared after reset;
// only entries below a path depth are ever read.
module hid_usage_path_stack_matcher_core
    import hupsm_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  item,
    output logic done,
    output out_t result
);

    localparam int DW   = $clog2(MAX_DEPTH + 1);
    localparam int AW   = $clog2(2 * MAX_DEPTH);
    localparam int NENT = 2 * MAX_DEPTH;
    localparam logic [AW-1:0] QBASE = AW'(MAX_DEPTH);
    localparam logic [DW-1:0] DMAX  = DW'(MAX_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    // zero is a wildcard on either side
    function automatic logic same_val(input logic [15:0] a, input logic [15:0] b);
        return (a == b) || (a == 16'd0) || (b == 16'd0);
    endfunction

    state_t        state_reg, state_next;
    logic [DW-1:0] depth_reg [2];
    logic [DW-1:0] depth_next [2];
    logic [7:0]    rid_reg [2];
    logic [7:0]    rid_next [2];
    logic          done_reg, done_next;
    out_t          result_reg, result_next;

    // walk context
    logic [2:0]    mode_reg, mode_next;
    logic          page_only_reg, page_only_next;
    logic [DW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] idx_reg, idx_next;
    logic          chk_valid_reg, chk_valid_next;
    logic          chk_last_reg, chk_last_next;

    // ram ports
    logic          page_we, usage_we;
    logic [AW-1:0] waddr;
    logic [15:0]   page_wdata, usage_wdata;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [15:0]   rpage_a, rpage_b, rusage_a, rusage_b;

    // item decode
    logic          acc;
    logic [DW-1:0] d_sel, rd, qd, d_sel_new;
    logic          full, empty;
    logic [AW-1:0] base;
    logic          rid_fail;

    // walk datapath
    logic          issue;
    logic [DW-1:0] ri, qi;
    logic          hit, finish, fin_match;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign acc   = start && !busy;
    assign d_sel = depth_reg[item.path_sel];
    assign rd    = depth_reg[PATH_REPORT];
    assign qd    = depth_reg[PATH_QUERY];
    assign full  = (d_sel >= DMAX);
    assign empty = (d_sel == '0);
    assign base  = (item.path_sel == PATH_QUERY) ? QBASE : '0;

    assign rid_fail = (rid_reg[PATH_QUERY] != 8'd0) &&
                      (rid_reg[PATH_QUERY] != rid_reg[PATH_REPORT]);

    // stack edits write straight into the rams
    always_comb
    begin
        page_we     = 1'b0;
        usage_we    = 1'b0;
        waddr       = base + AW'(d_sel - DW'(1));
        page_wdata  = 16'd0;
        usage_wdata = 16'd0;
        unique case (item.cmd)
            CMD_PUSH:
            begin
                waddr       = base + AW'(d_sel);
                page_wdata  = item.push_page;
                usage_wdata = item.usage;
                page_we     = acc && !full;
                usage_we    = acc && !full;
            end
            CMD_SET_LAST:
            begin
                page_wdata  = item.tag_value;
                usage_wdata = item.tag_value;
                page_we     = acc && !empty && (item.tag_class == TAG_GLOBAL);
                usage_we    = acc && !empty && (item.tag_class != TAG_GLOBAL);
            end
            CMD_ZERO_LAST:
            begin
                page_we  = acc && !empty;
                usage_we = acc && !empty;
            end
            default:
            begin
            end
        endcase
    end

    // depth of the selected path after an edit
    always_comb
    begin
        d_sel_new = d_sel;
        unique case (item.cmd)
            CMD_PUSH:  d_sel_new = full ? d_sel : d_sel + DW'(1);
            CMD_POP:   d_sel_new = empty ? d_sel : d_sel - DW'(1);
            CMD_CLEAR: d_sel_new = '0;
            default:   d_sel_new = d_sel;
        endcase
    end

    // walk addresses: suffix runs from the top of both paths
    always_comb
    begin
        issue = (state_reg == S_WALK) && (idx_reg < cnt_reg);
        ri    = (mode_reg == MODE_SUFFIX) ? rd - DW'(1) - idx_reg : idx_reg;
        if (mode_reg == MODE_ANYWHERE)
        begin
            qi = '0;
        end
        else if (mode_reg == MODE_SUFFIX)
        begin
            qi = qd - DW'(1) - idx_reg;
        end
        else
        begin
            qi = idx_reg;
        end
        raddr_a = AW'(ri);
        raddr_b = QBASE + AW'(qi);
    end

    // check of the pair read in the previous cycle
    always_comb
    begin
        hit = same_val(rpage_a, rpage_b) &&
              (page_only_reg || same_val(rusage_a, rusage_b));
        finish    = 1'b0;
        fin_match = 1'b0;
        if (chk_valid_reg)
        begin
            if (mode_reg == MODE_ANYWHERE)
            begin
                finish    = hit || chk_last_reg;
                fin_match = hit;
            end
            else
            begin
                finish    = !hit || chk_last_reg;
                fin_match = hit;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        rid_next       = rid_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mode_next      = mode_reg;
        page_only_next = page_only_reg;
        cnt_next       = cnt_reg;
        idx_next       = issue ? idx_reg + DW'(1) : idx_reg;
        chk_valid_next = issue && !finish;
        chk_last_next  = (idx_reg == cnt_reg - DW'(1));

        if (acc)
        begin
            depth_next[item.path_sel] = d_sel_new;
            if (item.cmd == CMD_SET_RID)
            begin
                rid_next[item.path_sel] = item.rid_value;
            end
            result_next.depth   = DEPTH_W'(d_sel_new);
            result_next.matched = 1'b0;
            result_next.status  = STATUS_OK;
            done_next           = 1'b1;
            if (item.cmd == CMD_PUSH && full)
            begin
                result_next.status = STATUS_FULL;
            end
            if (item.cmd == CMD_COMPARE)
            begin
                // decisions that need no entry, in rule order
                priority if (rid_fail)
                begin
                end
                else if (qd == '0)
                begin
                    result_next.matched = 1'b1;
                end
                else if (item.mode > MODE_ANYWHERE)
                begin
                    result_next.status = STATUS_BADMODE;
                end
                else if (item.mode == MODE_STRICT && rd != qd)
                begin
                end
                else if (item.mode != MODE_ANYWHERE && qd > rd)
                begin
                end
                else if (item.mode == MODE_ANYWHERE && (qd != DW'(1) || rd == '0))
                begin
                end
                else
                begin
                    done_next      = 1'b0;
                    state_next     = S_WALK;
                    mode_next      = item.mode;
                    page_only_next = item.page_only;
                    cnt_next       = (item.mode == MODE_ANYWHERE) ? rd : qd;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                end
            end
        end
        else if (state_reg == S_WALK && finish)
        begin
            state_next          = S_IDLE;
            done_next           = 1'b1;
            result_next.matched = fin_match;
            result_next.status  = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg[0]  <= '0;
            depth_reg[1]  <= '0;
            rid_reg[0]    <= 8'd0;
            rid_reg[1]    <= 8'd0;
            done_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            rid_reg       <= rid_next;
            done_reg      <= done_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        mode_reg      <= mode_next;
        page_only_reg <= page_only_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        chk_last_reg  <= chk_last_next;
    end

    // entry i of path p sits at p*MAX_DEPTH+i
    hupsm_ram #(
        .WIDTH (16),
        .DEPTH (NENT),
        .ADDR_W(AW)
    ) u_page_ram (
        .clk    (clk),
        .we     (page_we),
        .waddr  (waddr),
        .wdata  (page_wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rpage_a),
        .rdata_b(rpage_b)
    );

    hupsm_ram #(
        .WIDTH (16),
        .DEPTH (NENT),
        .ADDR_W(AW)
    ) u_usage_ram (
        .clk    (clk),
        .we     (usage_we),
        .waddr  (waddr),
        .wdata  (usage_wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rusage_a),
        .rdata_b(rusage_b)
    );

endmodule

/* rtl/core/hupsm_checker.sv */
// port-level checks of the matcher and their bind
`include "hid_usage_path_stack_matcher_core_assert.svh"

module hupsm_checker
    import hupsm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input in_t  item,
    input logic done,
    input out_t result
);

    // a result never shows while an item is still in work
    `HUPSM_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy)

    // anything but a compare answers in the next cycle
    `HUPSM_ASSERT_NXT(a_edit_one_cycle, clk, rst_n, start && !busy && item.cmd != CMD_COMPARE, done && !busy)

    // a match only comes with an ok status
    `HUPSM_ASSERT_NOW(a_match_ok, clk, rst_n, done && result.matched, result.status == STATUS_OK)

    // busy only rises after an accepted item
    `HUPSM_ASSERT_NOW(a_busy_cause, clk, rst_n, $rose(busy), $past(start))

endmodule

bind hid_usage_path_stack_matcher_core hupsm_checker u_hupsm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
);

/* verif/hid_usage_path_stack_matcher_core_test.sv */
// self-checking testbench of the hid usage path stack matcher core
module hid_usage_path_stack_matcher_core_test;
    import hupsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEPTH = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_LIMIT = 500;

    // codes the package does not name
    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam logic [2:0] MODE_BAD_LO  = 3'd4;
    localparam logic [2:0] MODE_BAD_HI  = 3'd7;
    localparam logic       TAG_LOCAL    = 1'b1;

    typedef struct {
        in_t  it;
        int   reps;
        bit   typed;
        out_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  item;
    logic done;
    out_t result;

    hid_usage_path_stack_matcher_core #(
        .MAX_DEPTH(MAX_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result)
    );

    // shadow copy of both paths: entry i of path p at p*MAX_DEPTH+i
    logic [15:0] stored_page  [2*MAX_DEPTH];
    logic [15:0] stored_usage [2*MAX_DEPTH];
    int          path_len     [2];
    logic [7:0]  path_rid     [2];

    out_t        pending_results [$];
    stim_row_t   directed_rows [$];
    in_t         episode_items [$];
    int          fail_cnt;
    int          quiet_cycles;
    bit          idle_on;
    out_t        oldest;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // zero on either side is a wildcard
    function automatic bit wild_eq(logic [15:0] a, logic [15:0] b);
        return (a == b) || (a == 16'h0000) || (b == 16'h0000);
    endfunction

    function automatic bit entry_pair_ok(int ri, int qi, logic pages_only);
        if (!wild_eq(stored_page[ri], stored_page[qi]))
            return 1'b0;
        return pages_only || wild_eq(stored_usage[ri], stored_usage[qi]);
    endfunction

    // query path against report path; rid test and empty query come first
    function automatic void compare_paths(input logic [2:0] md, input logic po,
                                          output logic [1:0] st, output logic hit);
        int rd;
        int qd;
        rd = path_len[PATH_REPORT];
        qd = path_len[PATH_QUERY];
        st = STATUS_OK;
        hit = 1'b0;
        if (path_rid[PATH_QUERY] != 8'h00 && path_rid[PATH_QUERY] != path_rid[PATH_REPORT])
            return;
        if (qd == 0)
        begin
            hit = 1'b1;
            return;
        end
        case (md)
            MODE_STRICT, MODE_PREFIX:
            begin
                if ((md == MODE_STRICT && rd != qd) || qd > rd)
                    return;
                hit = 1'b1;
                for (int i = 0; i < qd; i++)
                    if (!entry_pair_ok(i, MAX_DEPTH + i, po))
                        hit = 1'b0;
            end
            MODE_SUFFIX:
            begin
                if (qd > rd)
                    return;
                hit = 1'b1;
                for (int i = 0; i < qd; i++)
                    if (!entry_pair_ok(rd - 1 - i, MAX_DEPTH + qd - 1 - i, po))
                        hit = 1'b0;
            end
            MODE_ANYWHERE:
            begin
                if (qd != 1)
                    return;
                for (int i = 0; i < rd; i++)
                    if (entry_pair_ok(i, MAX_DEPTH, po))
                        hit = 1'b1;
            end
            default:
                st = STATUS_BADMODE;
        endcase
    endfunction

    // applies one item to the shadow paths and returns the result it gives
    function automatic out_t path_stack_step(in_t it);
        out_t        r;
        int          p;
        int          d;
        int          base;
        logic [1:0]  st;
        logic        hit;
        p = it.path_sel;
        d = path_len[p];
        base = p * MAX_DEPTH;
        r = '0;
        case (it.cmd)
            CMD_PUSH:
            begin
                if (d >= MAX_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    stored_page[base + d] = it.push_page;
                    stored_usage[base + d] = it.usage;
                    path_len[p] = d + 1;
                end
            end
            CMD_POP:
            begin
                if (d > 0)
                    path_len[p] = d - 1;
            end
            CMD_SET_LAST:
            begin
                if (d > 0)
                begin
                    if (it.tag_class == TAG_GLOBAL)
                        stored_page[base + d - 1] = it.tag_value;
                    else
                        stored_usage[base + d - 1] = it.tag_value;
                end
            end
            CMD_ZERO_LAST:
            begin
                if (d > 0)
                begin
                    stored_page[base + d - 1] = 16'h0000;
                    stored_usage[base + d - 1] = 16'h0000;
                end
            end
            CMD_SET_RID:
                path_rid[p] = it.rid_value;
            CMD_CLEAR:
                path_len[p] = 0;
            CMD_COMPARE:
            begin
                compare_paths(it.mode, it.page_only, st, hit);
                r.status = st;
                r.matched = hit;
            end
            default:
                ;
        endcase
        r.depth = 5'(path_len[p]);
        return r;
    endfunction

    function automatic in_t make_item(logic [2:0] cmd, logic sel, logic [15:0] page,
                                      logic [15:0] usg, logic tclass, logic [15:0] tvalue,
                                      logic [7:0] rid, logic [2:0] md, logic po);
        in_t it;
        it.cmd = cmd;
        it.path_sel = sel;
        it.push_page = page;
        it.usage = usg;
        it.tag_class = tclass;
        it.tag_value = tvalue;
        it.rid_value = rid;
        it.mode = md;
        it.page_only = po;
        return it;
    endfunction

    function automatic in_t random_item();
        return make_item(3'($urandom_range(0, 7)), 1'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom), 16'($urandom), 8'($urandom),
                         3'($urandom_range(0, 7)), 1'($urandom));
    endfunction

    // values from a small pool so that entries collide and matches happen
    function automatic logic [15:0] pick_val();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 16'h0000;
        if (r < 5)
            return 16'($urandom_range(1, 3));
        if (r == 5)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic void add_row(in_t it, int reps, bit typed, out_t want);
        stim_row_t row;
        row.it = it;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // start stays high from one item to the next when there is no gap, so
    // it is only lowered when a gap is drawn
    task automatic send_item(input in_t it, input bit typed, input out_t want);
        int   gap;
        out_t predicted;
        if ($urandom_range(0, 49) == 0)
            idle_on = !idle_on;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // item taken at this edge
        predicted = path_stack_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // one well-formed episode (report path, query built from it, compares),
    // or a burst of fully random items
    task automatic build_episode();
        in_t         it;
        int          n_r;
        int          n_q;
        int          first;
        int          src;
        logic [2:0]  style;
        logic [7:0]  rid;
        logic [15:0] rp [MAX_DEPTH];
        logic [15:0] ru [MAX_DEPTH];
        logic [15:0] pg;
        logic [15:0] us;
        episode_items.delete();
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(3, 8)) episode_items.push_back(random_item());
            return;
        end
        it = random_item();
        it.cmd = CMD_CLEAR;
        it.path_sel = PATH_REPORT;
        episode_items.push_back(it);
        it = random_item();
        it.cmd = CMD_CLEAR;
        it.path_sel = PATH_QUERY;
        episode_items.push_back(it);
        rid = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
        it = random_item();
        it.cmd = CMD_SET_RID;
        it.path_sel = PATH_REPORT;
        it.rid_value = rid;
        episode_items.push_back(it);
        it = random_item();
        it.cmd = CMD_SET_RID;
        it.path_sel = PATH_QUERY;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.rid_value = 8'h00;
            5, 6, 7:       it.rid_value = rid;
            default:       it.rid_value = 8'($urandom);
        endcase
        episode_items.push_back(it);
        // mostly short report paths, now and then a deep one
        n_r = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_DEPTH) : $urandom_range(0, 5);
        for (int i = 0; i < n_r; i++)
        begin
            rp[i] = pick_val();
            ru[i] = pick_val();
            it = random_item();
            it.cmd = CMD_PUSH;
            it.path_sel = PATH_REPORT;
            it.push_page = rp[i];
            it.usage = ru[i];
            episode_items.push_back(it);
        end
        if (n_r == MAX_DEPTH && $urandom_range(0, 1))
        begin
            it = random_item();
            it.cmd = CMD_PUSH;
            it.path_sel = PATH_REPORT;
            episode_items.push_back(it);
        end
        style = 3'($urandom_range(0, 3));
        case (style)
            MODE_STRICT:
            begin
                n_q = n_r;
                first = 0;
            end
            MODE_PREFIX:
            begin
                n_q = $urandom_range(0, n_r);
                first = 0;
            end
            MODE_SUFFIX:
            begin
                n_q = $urandom_range(0, n_r);
                first = n_r - n_q;
            end
            default:
            begin
                n_q = 1;
                first = (n_r > 0) ? $urandom_range(0, n_r - 1) : 0;
            end
        endcase
        if ($urandom_range(0, 9) == 0)
            n_q = $urandom_range(0, 2);
        for (int i = 0; i < n_q; i++)
        begin
            src = first + i;
            pg = (src < n_r) ? rp[src] : pick_val();
            us = (src < n_r) ? ru[src] : pick_val();
            case ($urandom_range(0, 9))
                0:       pg = 16'h0000;
                1:       us = 16'h0000;
                2:       pg = pick_val();
                3:       us = pick_val();
                default: ;
            endcase
            it = random_item();
            it.cmd = CMD_PUSH;
            it.path_sel = PATH_QUERY;
            it.push_page = pg;
            it.usage = us;
            episode_items.push_back(it);
        end
        // an occasional edit of the last entry before comparing
        if ($urandom_range(0, 4) == 0)
        begin
            it = random_item();
            case ($urandom_range(0, 2))
                0:       it.cmd = CMD_POP;
                1:       it.cmd = CMD_SET_LAST;
                default: it.cmd = CMD_ZERO_LAST;
            endcase
            if ($urandom_range(0, 1))
                it.tag_value = pick_val();
            episode_items.push_back(it);
        end
        repeat ($urandom_range(1, 3))
        begin
            it = random_item();
            it.cmd = CMD_COMPARE;
            if ($urandom_range(0, 9) < 7)
                it.mode = style;
            episode_items.push_back(it);
        end
    endtask

    // results: each one is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item waiting: status %0d matched %0d depth %0d",
                       result.status, result.matched, result.depth);
                fail_cnt++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result.status !== oldest.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest.status, result.status);
                    fail_cnt++;
                end
                if (result.matched !== oldest.matched)
                begin
                    $error("matched: expected %0d, actual %0d", oldest.matched,
                           result.matched);
                    fail_cnt++;
                end
                if (result.depth !== oldest.depth)
                begin
                    $error("depth: expected %0d, actual %0d", oldest.depth, result.depth);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: too long without an item taken or a result given
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int sent;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        fail_cnt = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        for (int i = 0; i < 2 * MAX_DEPTH; i++)
        begin
            stored_page[i] = 16'h0000;
            stored_usage[i] = 16'h0000;
        end
        path_len[0] = 0;
        path_len[1] = 0;
        path_rid[0] = 8'h00;
        path_rid[1] = 8'h00;

        // directed part: rows with a typed-in result are checked against it
        // empty query matches whatever the mode, even an invalid one
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_STRICT, 1'b0), 1, 1, out_t'{STATUS_OK, 1'b1, 5'd0});
        add_row(make_item(CMD_COMPARE, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_BAD_HI, 1'b1), 1, 1, out_t'{STATUS_OK, 1'b1, 5'd0});
        add_row(make_item(CMD_PUSH, PATH_REPORT, 16'hFFFF, 16'hFFFF, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_PUSH, PATH_REPORT, 16'h0001, 16'h0000, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_PUSH, PATH_QUERY, 16'hFFFF, 16'h0000, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_PREFIX, 1'b0), 1, 0, '0);
        // invalid mode with a nonempty query
        add_row(make_item(CMD_COMPARE, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_BAD_LO, 1'b1), 1, 1, out_t'{STATUS_BADMODE, 1'b0, 5'd1});
        // report id mismatch, then the ids agree
        add_row(make_item(CMD_SET_RID, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'hFF,
                          MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_SUFFIX, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_SET_RID, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'hFF,
                          MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_SUFFIX, 1'b1), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_ANYWHERE, 1'b0), 1, 0, '0);
        // set last, page then usage, on the query
        add_row(make_item(CMD_SET_LAST, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h1234,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_SET_LAST, PATH_QUERY, 16'h0, 16'h0, TAG_LOCAL, 16'hFFFF,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_ANYWHERE, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_ZERO_LAST, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_SUFFIX, 1'b0), 1, 0, '0);
        // pop down to empty, then edits on an empty path do nothing
        add_row(make_item(CMD_POP, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_STRICT, 1'b0), 2, 0, '0);
        add_row(make_item(CMD_SET_LAST, PATH_QUERY, 16'h0, 16'h0, TAG_LOCAL, 16'hFFFF,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_ZERO_LAST, PATH_QUERY, 16'h0, 16'h0, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), 1, 1, out_t'{STATUS_OK, 1'b0, 5'd0});
        add_row(make_item(CMD_UNUSED, PATH_REPORT, 16'hFFFF, 16'hFFFF, TAG_LOCAL, 16'hFFFF,
                          8'hFF, MODE_BAD_HI, 1'b1), 1, 0, '0);
        add_row(make_item(CMD_CLEAR, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_STRICT, 1'b0), 1, 1, out_t'{STATUS_OK, 1'b0, 5'd0});
        // fill the report path, then one push too many
        add_row(make_item(CMD_PUSH, PATH_REPORT, 16'h8000, 16'h0001, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), MAX_DEPTH, 0, '0);
        add_row(make_item(CMD_PUSH, PATH_REPORT, 16'hFFFF, 16'hFFFF, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), 1, 1,
                out_t'{STATUS_FULL, 1'b0, 5'(MAX_DEPTH)});
        add_row(make_item(CMD_PUSH, PATH_QUERY, 16'h0000, 16'h0001, TAG_GLOBAL, 16'h0,
                          8'h00, MODE_STRICT, 1'b0), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_ANYWHERE, 1'b1), 1, 0, '0);
        add_row(make_item(CMD_COMPARE, PATH_REPORT, 16'h0, 16'h0, TAG_GLOBAL, 16'h0, 8'h00,
                          MODE_SUFFIX, 1'b0), 1, 0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);

        // random part, episodes until enough items have gone in
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            build_episode();
            foreach (episode_items[k])
            begin
                send_item(episode_items[k], 1'b0, '0);
                sent++;
            end
        end
        start <= 1'b0;

        // drain, then let a full compare walk pass
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (MAX_DEPTH + 8) @(posedge clk);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/hupsm_pkg.sv
rtl/core/hupsm_ram.sv
rtl/core/hid_usage_path_stack_matcher_core.sv
rtl/core/hupsm_checker.sv
verif/hid_usage_path_stack_matcher_core_test.sv
